// File: hdl/scrm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the step command run merger.
// No dependencies; used by every module of the block.
package scrm_pkg;

    localparam int NUM_MOTORS   = 4;
    localparam int CODE_W       = 2;
    localparam int CODES_W      = NUM_MOTORS * CODE_W;
    localparam int COUNT_W      = 28;
    localparam int MERGED_W     = COUNT_W + 1;

    // A held run above this count takes no further merges.
    localparam logic [MERGED_W-1:0] MERGE_LIMIT = 29'h0fff_ffff;

    // Number of result slots in the output queue.
    localparam int QUEUE_DEPTH  = 2;

    // One accepted input item.
    typedef struct packed {
        logic [CODES_W-1:0] codes;
        logic [COUNT_W-1:0] count;
        logic               last;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [CODES_W-1:0]  codes;
        logic [MERGED_W-1:0] count;
        logic                final_flag;
    } res_t;

    // Results produced by one item, in delivery order.
    typedef struct packed {
        logic [1:0] num;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

// File: hdl/scrm_core.sv
`timescale 1ns / 1ps
// Run merge logic: holds the current run and works out the results of one item.
// Depends on scrm_pkg.
module scrm_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  scrm_pkg::cmd_t item,
    input  logic           fire,
    output scrm_pkg::push_t push
);
    import scrm_pkg::*;

    logic                held_valid_reg, held_valid_next;
    logic [CODES_W-1:0]  held_codes_reg, held_codes_next;
    logic [MERGED_W-1:0] held_count_reg, held_count_next;

    logic                nonzero;
    logic                merge;
    logic                displace;
    logic                post_valid;
    logic [CODES_W-1:0]  post_codes;
    logic [MERGED_W-1:0] post_count;
    logic                flush;
    res_t                held_res;
    res_t                post_res;

    // Decide whether the item merges into the held run or starts a new one.
    always_comb begin
        nonzero  = (item.count != '0);
        merge    = nonzero && held_valid_reg && (held_codes_reg == item.codes)
                   && (held_count_reg <= MERGE_LIMIT);
        displace = nonzero && !merge && held_valid_reg;

        post_valid = held_valid_reg;
        post_codes = held_codes_reg;
        post_count = held_count_reg;
        if (merge) begin
            post_count = held_count_reg + {1'b0, item.count};
        end else if (nonzero) begin
            post_valid = 1'b1;
            post_codes = item.codes;
            post_count = {1'b0, item.count};
        end
        flush = item.last && post_valid;
    end

    // Results in order: displaced run first, then the final flush.
    always_comb begin
        held_res = '{codes: held_codes_reg, count: held_count_reg, final_flag: 1'b0};
        post_res = '{codes: post_codes, count: post_count, final_flag: 1'b1};
        push.num    = {1'b0, displace} + {1'b0, flush};
        push.first  = displace ? held_res : post_res;
        push.second = post_res;
    end

    // The last item of a list leaves nothing held.
    always_comb begin
        held_valid_next = held_valid_reg;
        held_codes_next = held_codes_reg;
        held_count_next = held_count_reg;
        if (fire) begin
            if (item.last) begin
                held_valid_next = 1'b0;
                held_codes_next = '0;
                held_count_next = '0;
            end else begin
                held_valid_next = post_valid;
                held_codes_next = post_codes;
                held_count_next = post_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_codes_reg <= '0;
            held_count_reg <= '0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_codes_reg <= held_codes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

// File: hdl/scrm_queue.sv
`timescale 1ns / 1ps
// Two-slot result queue: takes up to two results a cycle, delivers one.
// Depends on scrm_pkg.
module scrm_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  scrm_pkg::push_t push,
    input  logic            push_en,
    output logic [1:0]      free_slots,
    output scrm_pkg::res_t  head,
    output logic            head_valid,
    input  logic            pop
);
    import scrm_pkg::*;

    res_t       entry_reg [QUEUE_DEPTH];
    res_t       entry_next [QUEUE_DEPTH];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] push_num;

    assign push_num   = push_en ? push.num : 2'd0;
    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);
    // A slot being read out this cycle may be refilled at the same edge.
    assign free_slots = 2'(QUEUE_DEPTH) - count_reg + {1'b0, pop};

    // Slot writes: the first result at the write pointer, the second after it.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
            if (push_num != 2'd0 && wr_ptr_reg == 1'(i)) begin
                entry_next[i] = push.first;
            end
            if (push_num == 2'd2 && wr_ptr_reg != 1'(i)) begin
                entry_next[i] = push.second;
            end
        end
        wr_ptr_next = wr_ptr_reg ^ push_num[0];
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + push_num - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/step_command_run_merger.sv
`timescale 1ns / 1ps
// Top level of the step command run merger: input register, merge core, result queue.
// Depends on scrm_pkg, scrm_core and scrm_queue.
//
// Usage:
//   Input channel s_*: one stepper command per item (four motor codes, a
//   28-bit repeat count and an is_last mark), valid/ready handshake.
//   Result channel m_*: merged runs with a 29-bit count and a final flag.
//   An accepted item waits in the input register, is compared with the held
//   run and its results are written into a two-slot queue once the queue has
//   room for them; the results are offered on m_* from the queue head.
//   One item is taken per cycle while each item yields at most one result
//   and the receiver does not stall; an item that yields two results can hold
//   back later items, since the queue delivers one result per cycle.
//   Items with a zero count are dropped; a last item flushes the held run.
//   When the receiver stalls, results stay in the queue and the input
//   register holds its item until the queue has room for its results,
//   with s_ready low meanwhile. Reset empties the queue and clears the held run.
module step_command_run_merger (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [scrm_pkg::CODE_W-1:0]       s_motor0_code,
    input  logic [scrm_pkg::CODE_W-1:0]       s_motor1_code,
    input  logic [scrm_pkg::CODE_W-1:0]       s_motor2_code,
    input  logic [scrm_pkg::CODE_W-1:0]       s_motor3_code,
    input  logic [scrm_pkg::COUNT_W-1:0]      s_repeat_count,
    input  logic                              s_is_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [scrm_pkg::CODE_W-1:0]       m_out_motor0_code,
    output logic [scrm_pkg::CODE_W-1:0]       m_out_motor1_code,
    output logic [scrm_pkg::CODE_W-1:0]       m_out_motor2_code,
    output logic [scrm_pkg::CODE_W-1:0]       m_out_motor3_code,
    output logic [scrm_pkg::MERGED_W-1:0]     m_merged_count,
    output logic                              m_final_flag
);
    import scrm_pkg::*;

    logic       in_valid_reg, in_valid_next;
    cmd_t       in_item_reg, in_item_next;
    push_t      push;
    logic       fire;
    logic [1:0] free_slots;
    res_t       head;
    logic       pop;

    // The held item goes ahead once the queue can take all of its results.
    assign fire    = in_valid_reg && (push.num <= free_slots);
    assign s_ready = !in_valid_reg || fire;
    assign pop     = m_valid && m_ready;

    // Input register.
    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_item_next  = '{codes: {s_motor3_code, s_motor2_code,
                                      s_motor1_code, s_motor0_code},
                              count: s_repeat_count,
                              last:  s_is_last};
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    scrm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_item_reg),
        .fire    (fire),
        .push    (push)
    );

    scrm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_en    (fire),
        .free_slots (free_slots),
        .head       (head),
        .head_valid (m_valid),
        .pop        (pop)
    );

    // Result fields from the queue head.
    assign m_out_motor0_code = head.codes[1*CODE_W-1:0*CODE_W];
    assign m_out_motor1_code = head.codes[2*CODE_W-1:1*CODE_W];
    assign m_out_motor2_code = head.codes[3*CODE_W-1:2*CODE_W];
    assign m_out_motor3_code = head.codes[4*CODE_W-1:3*CODE_W];
    assign m_merged_count    = head.count;
    assign m_final_flag      = head.final_flag;

endmodule

// File: hdl/scrm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the step command run merger, bound to the top level.
// Depends on scrm_pkg and step_command_run_merger.
module scrm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [scrm_pkg::MERGED_W-1:0] m_merged_count
);
    import scrm_pkg::*;

    // A stalled result item stays offered.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item withdrawn while stalled");

    // A delivered run never has a zero count.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_merged_count != '0)
        else $error("result item with zero count");

    // A run is at most two limit-sized counts.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_merged_count <= MERGE_LIMIT + MERGE_LIMIT)
        else $error("merged count beyond two saturated runs");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result item offered straight after reset");

endmodule

bind step_command_run_merger scrm_checker u_scrm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_merged_count (m_merged_count)
);
